FILE: rtl/slpcp_pkg.sv
// Package for the serial LED PWM command parser: sizes, codes and command text.
`timescale 1ns / 1ps

package slpcp_pkg;

   // Command store size and the width of its length counter.
   localparam int STORE_DEPTH = 32;
   localparam int LEN_W       = $clog2(STORE_DEPTH);

   typedef logic [LEN_W-1:0] len_type;

   // Special characters.
   localparam logic [7:0] CHAR_END   = 8'h21;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Duty limits.
   localparam logic [6:0] DUTY_MAX   = 7'd100;
   localparam logic [6:0] DUTY_RESET = 7'd50;

   // Reply codes.
   typedef enum logic [2:0] {
      KIND_ON      = 3'd0,
      KIND_OFF     = 3'd1,
      KIND_DUTY    = 3'd2,
      KIND_STATUS  = 3'd3,
      KIND_UNKNOWN = 3'd4
   } reply_kind_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   // Character k of "ON".
   function automatic logic [7:0] on_char(input logic k);
      logic [7:0] c;
      c = k ? 8'h4E : 8'h4F;
      return c;
   endfunction

   // Character k of "OFF".
   function automatic logic [7:0] off_char(input logic [1:0] k);
      logic [7:0] c;
      c = (k == 2'd0) ? 8'h4F : 8'h46;
      return c;
   endfunction

   // Character k of "PWM:".
   function automatic logic [7:0] pwm_char(input logic [1:0] k);
      logic [7:0] c;
      case (k)
         2'd0:    c = 8'h50;
         2'd1:    c = 8'h57;
         2'd2:    c = 8'h4D;
         default: c = 8'h3A;
      endcase
      return c;
   endfunction

   // Character k of "Status".
   function automatic logic [7:0] status_char(input logic [2:0] k);
      logic [7:0] c;
      case (k)
         3'd0:    c = 8'h53;
         3'd1:    c = 8'h74;
         3'd2:    c = 8'h61;
         3'd3:    c = 8'h74;
         3'd4:    c = 8'h75;
         default: c = 8'h73;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/serial_led_pwm_command_parser_top.sv
// Top level of the serial LED PWM command parser.
`timescale 1ns / 1ps

// Takes received characters one item at a time. An ordinary character, CR or LF
// is taken in the idle state. A '!' starts a walk over the stored command: the
// sequencer reads the command memory one character per cycle through its single
// read port and checks each character with one shared compare and times-ten unit.
// After the '!' the block is busy while it walks the command (at most 31 stored
// characters) and while it decides the reply. It stays busy longer while an
// earlier reply still waits in the output register, because the new reply is
// loaded only once that register is free. The next item is accepted as soon as
// the reply is loaded, even while that reply still waits to be taken.
module serial_led_pwm_command_parser_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_reply_kind,
   output logic       rsp_led_on,
   output logic [6:0] rsp_duty_percent,
   output logic [9:0] rsp_compare_value,
   output logic       rsp_compare_written
);

   // Command memory and its read data.
   logic [7:0] cmd_store_ff [slpcp_pkg::STORE_DEPTH];
   logic [7:0] rd_data_ff;

   // Sequencer and walk state.
   slpcp_pkg::state_type state_ff, state_in;
   slpcp_pkg::len_type   len_ff, len_in;
   slpcp_pkg::len_type   rd_idx_ff, rd_idx_in;
   slpcp_pkg::len_type   chk_idx_ff, chk_idx_in;
   logic                 chk_valid_ff, chk_valid_in;
   logic                 on_ok_ff, on_ok_in;
   logic                 off_ok_ff, off_ok_in;
   logic                 pwm_ok_ff, pwm_ok_in;
   logic                 status_ok_ff, status_ok_in;
   logic                 digit_run_ff, digit_run_in;
   logic [6:0]           acc_ff, acc_in;

   // Persistent output state.
   logic       enabled_ff, enabled_in;
   logic [6:0] duty_ff, duty_in;
   logic [9:0] compare_ff, compare_in;

   // Output register.
   logic                      rsp_valid_ff, rsp_valid_in;
   slpcp_pkg::reply_kind_type rsp_kind_ff, rsp_kind_in;
   logic                      rsp_led_ff, rsp_led_in;
   logic [6:0]                rsp_duty_ff, rsp_duty_in;
   logic [9:0]                rsp_cmp_ff, rsp_cmp_in;
   logic                      rsp_wr_ff, rsp_wr_in;

   // Shared times-ten unit and helpers.
   logic [6:0] mul_in;
   logic [9:0] mul_out;
   logic [9:0] digit_sum;
   logic       is_digit;
   logic       store_wr;
   logic       req_take;
   logic       on_hit, off_hit, pwm_hit, status_hit;

   assign req_ready = (state_ff == slpcp_pkg::ST_IDLE);
   assign req_take  = req_valid && req_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_reply_kind      = rsp_kind_ff;
   assign rsp_led_on          = rsp_led_ff;
   assign rsp_duty_percent    = rsp_duty_ff;
   assign rsp_compare_value   = rsp_cmp_ff;
   assign rsp_compare_written = rsp_wr_ff;

   // A store write happens for an ordinary character while there is room.
   assign store_wr = req_take && (req_rx_byte != slpcp_pkg::CHAR_END) &&
                     (req_rx_byte != slpcp_pkg::CHAR_CR) &&
                     (req_rx_byte != slpcp_pkg::CHAR_LF) &&
                     (len_ff < slpcp_pkg::LEN_W'(slpcp_pkg::STORE_DEPTH - 1));

   // Command memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (store_wr) begin
         cmd_store_ff[len_ff] <= req_rx_byte;
      end
      rd_data_ff <= cmd_store_ff[rd_idx_ff];
   end

   // Final decisions from the match flags and the stored length.
   assign on_hit     = on_ok_ff && (len_ff == slpcp_pkg::LEN_W'(2));
   assign off_hit    = off_ok_ff && (len_ff == slpcp_pkg::LEN_W'(3));
   assign pwm_hit    = pwm_ok_ff && (len_ff >= slpcp_pkg::LEN_W'(4));
   assign status_hit = status_ok_ff && (len_ff == slpcp_pkg::LEN_W'(6));

   // Shared times-ten unit: digit accumulation during the walk, compare at the end.
   always_comb begin
      if (state_ff == slpcp_pkg::ST_DONE && on_hit) begin
         mul_in = duty_ff;
      end else begin
         mul_in = acc_ff;
      end
   end
   assign mul_out = ({3'b000, mul_in} << 3) + ({3'b000, mul_in} << 1);

   assign is_digit  = (rd_data_ff >= slpcp_pkg::CHAR_ZERO) &&
                      (rd_data_ff <= slpcp_pkg::CHAR_NINE);
   assign digit_sum = mul_out + {6'd0, rd_data_ff[3:0]};

   // Sequencer: next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      rd_idx_in    = rd_idx_ff;
      chk_idx_in   = chk_idx_ff;
      chk_valid_in = 1'b0;
      on_ok_in     = on_ok_ff;
      off_ok_in    = off_ok_ff;
      pwm_ok_in    = pwm_ok_ff;
      status_ok_in = status_ok_ff;
      digit_run_in = digit_run_ff;
      acc_in       = acc_ff;
      enabled_in   = enabled_ff;
      duty_in      = duty_ff;
      compare_in   = compare_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_led_in   = rsp_led_ff;
      rsp_duty_in  = rsp_duty_ff;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_wr_in    = rsp_wr_ff;

      unique case (state_ff)
         slpcp_pkg::ST_IDLE: begin
            if (req_take) begin
               if (req_rx_byte == slpcp_pkg::CHAR_END) begin
                  state_in     = slpcp_pkg::ST_WALK;
                  rd_idx_in    = '0;
                  on_ok_in     = 1'b1;
                  off_ok_in    = 1'b1;
                  pwm_ok_in    = 1'b1;
                  status_ok_in = 1'b1;
                  digit_run_in = 1'b1;
                  acc_in       = '0;
               end else if (req_rx_byte != slpcp_pkg::CHAR_CR &&
                            req_rx_byte != slpcp_pkg::CHAR_LF) begin
                  // A full store drops the character and restarts the command.
                  if (store_wr) begin
                     len_in = len_ff + slpcp_pkg::len_type'(1);
                  end else begin
                     len_in = '0;
                  end
               end
            end
         end

         slpcp_pkg::ST_WALK: begin
            // Issue one read per cycle until the whole command is read.
            if (rd_idx_ff < len_ff) begin
               chk_valid_in = 1'b1;
               chk_idx_in   = rd_idx_ff;
               rd_idx_in    = rd_idx_ff + slpcp_pkg::len_type'(1);
            end else if (!chk_valid_ff) begin
               state_in = slpcp_pkg::ST_DONE;
            end

            // Check the character read in the previous cycle.
            if (chk_valid_ff) begin
               if (chk_idx_ff < slpcp_pkg::LEN_W'(2) &&
                   rd_data_ff != slpcp_pkg::on_char(chk_idx_ff[0])) begin
                  on_ok_in = 1'b0;
               end
               if (chk_idx_ff < slpcp_pkg::LEN_W'(3) &&
                   rd_data_ff != slpcp_pkg::off_char(chk_idx_ff[1:0])) begin
                  off_ok_in = 1'b0;
               end
               if (chk_idx_ff < slpcp_pkg::LEN_W'(6) &&
                   rd_data_ff != slpcp_pkg::status_char(chk_idx_ff[2:0])) begin
                  status_ok_in = 1'b0;
               end
               if (chk_idx_ff < slpcp_pkg::LEN_W'(4)) begin
                  if (rd_data_ff != slpcp_pkg::pwm_char(chk_idx_ff[1:0])) begin
                     pwm_ok_in = 1'b0;
                  end
               end else if (digit_run_ff) begin
                  // Decimal digits after the prefix, saturating after each one.
                  if (is_digit) begin
                     if (digit_sum > {3'b000, slpcp_pkg::DUTY_MAX}) begin
                        acc_in = slpcp_pkg::DUTY_MAX;
                     end else begin
                        acc_in = digit_sum[6:0];
                     end
                  end else begin
                     digit_run_in = 1'b0;
                  end
               end
            end
         end

         slpcp_pkg::ST_DONE: begin
            // Wait until the output register is free, then act and reply.
            if (!rsp_valid_ff || rsp_ready) begin
               state_in     = slpcp_pkg::ST_IDLE;
               len_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_wr_in    = 1'b0;
               if (on_hit) begin
                  enabled_in  = 1'b1;
                  compare_in  = mul_out;
                  rsp_wr_in   = 1'b1;
                  rsp_kind_in = slpcp_pkg::KIND_ON;
               end else if (off_hit) begin
                  enabled_in  = 1'b0;
                  compare_in  = '0;
                  rsp_wr_in   = 1'b1;
                  rsp_kind_in = slpcp_pkg::KIND_OFF;
               end else if (pwm_hit) begin
                  duty_in = acc_ff;
                  if (enabled_ff) begin
                     compare_in = mul_out;
                     rsp_wr_in  = 1'b1;
                  end
                  rsp_kind_in = slpcp_pkg::KIND_DUTY;
               end else if (status_hit) begin
                  rsp_kind_in = slpcp_pkg::KIND_STATUS;
               end else begin
                  rsp_kind_in = slpcp_pkg::KIND_UNKNOWN;
               end
               rsp_led_in  = enabled_in;
               rsp_duty_in = duty_in;
               rsp_cmp_in  = compare_in;
            end
         end

         default: begin
            state_in = slpcp_pkg::ST_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slpcp_pkg::ST_IDLE;
         len_ff       <= '0;
         chk_valid_ff <= 1'b0;
         enabled_ff   <= 1'b0;
         duty_ff      <= slpcp_pkg::DUTY_RESET;
         compare_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         chk_valid_ff <= chk_valid_in;
         enabled_ff   <= enabled_in;
         duty_ff      <= duty_in;
         compare_ff   <= compare_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Walk datapath and reply payload registers.
   always_ff @(posedge clock) begin
      rd_idx_ff    <= rd_idx_in;
      chk_idx_ff   <= chk_idx_in;
      on_ok_ff     <= on_ok_in;
      off_ok_ff    <= off_ok_in;
      pwm_ok_ff    <= pwm_ok_in;
      status_ok_ff <= status_ok_in;
      digit_run_ff <= digit_run_in;
      acc_ff       <= acc_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_led_ff   <= rsp_led_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_cmp_ff   <= rsp_cmp_in;
      rsp_wr_ff    <= rsp_wr_in;
   end

endmodule

FILE: rtl/slpcp_checker.sv
// Port checker for the serial LED PWM command parser and its bind statement.
`timescale 1ns / 1ps

module slpcp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_reply_kind,
   input logic       rsp_led_on,
   input logic [6:0] rsp_duty_percent,
   input logic [9:0] rsp_compare_value,
   input logic       rsp_compare_written
);

   // A stalled reply holds its item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reply_kind) &&
      $stable(rsp_duty_percent) && $stable(rsp_compare_value))
      else $error("stalled reply changed");

   // A written compare level follows the enable and the duty.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_written |->
      (rsp_led_on ? (rsp_compare_value == {3'b000, rsp_duty_percent} * 10'd10)
                  : (rsp_compare_value == 10'd0)))
      else $error("written compare level does not match duty and enable");

   // An ON reply always enables the output and writes the compare level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reply_kind == slpcp_pkg::KIND_ON |->
      rsp_led_on && rsp_compare_written)
      else $error("ON reply without enable or compare write");

   // Status and unknown replies never write the compare level.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_reply_kind == slpcp_pkg::KIND_STATUS ||
                    rsp_reply_kind == slpcp_pkg::KIND_UNKNOWN) |->
      !rsp_compare_written)
      else $error("status or unknown reply wrote the compare level");

   // The duty never leaves its range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_duty_percent <= slpcp_pkg::DUTY_MAX)
      else $error("duty out of range");

endmodule

bind serial_led_pwm_command_parser_top slpcp_checker u_slpcp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_reply_kind      (rsp_reply_kind),
   .rsp_led_on          (rsp_led_on),
   .rsp_duty_percent    (rsp_duty_percent),
   .rsp_compare_value   (rsp_compare_value),
   .rsp_compare_written (rsp_compare_written)
);
